// ===== hw/rtl/wmmc_pkg.sv =====
//------------------------------------------------------------------------------
// wmmc_pkg
// Shared widths and constants of the window min/max confidence map.
//------------------------------------------------------------------------------
package wmmc_pkg;

    localparam int unsigned SAMPLE_W      = 17;
    localparam int unsigned SIZE_W        = 11;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned MAX_WIDTH     = 1024;
    localparam int unsigned MAX_HEIGHT    = 1024;
    localparam int unsigned WINDOW_HALF   = 3;
    localparam logic [SAMPLE_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [SAMPLE_W-1:0] HALF_Q16 = 17'd32768;
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd480;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Pipeline state of the result engine.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MATH,
        ST_SEND
    } t_state;

    // Saturate a 17-bit sample to 1.0.
    function automatic logic [SAMPLE_W-1:0] sat_q16(input logic [SAMPLE_W-1:0] v);
        sat_q16 = (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

// ===== hw/rtl/window_minmax_confidence_map_core.sv =====
//------------------------------------------------------------------------------
// window_minmax_confidence_map_core
// Combined confidence from a windowed min/max of foreground probability.
//------------------------------------------------------------------------------
// Usage: pixels enter on the s_axis channel, one beat per pixel: tdata holds
// the probability and confidence, tuser holds frame_start and flush. A flush
// beat carries no pixel and only drains results left at the end of a frame.
// Results leave on m_axis: tdata is the combined confidence, tlast marks the
// frame's last pixel. A result belongs to the pixel (L-1) rows and (L-1)
// pixels earlier, L = 2*WINDOW_HALF-1.
// Each beat is handled by one shared sequencer around the probability line
// memory. A beat that emits no result leaves the sequencer idle, so such
// beats can follow back to back. A beat that emits a result keeps the input
// closed until its result leaves the send stage: the sequencer reads the
// pixel itself, then for a filtered pixel one memory read per window tap,
// then a multiply stage and the send stage. Frame size registers are taken
// at the first pixel of a frame. Reset clears counters and control; the
// memories need no clearing since only entries written earlier in the
// frame are read. When the receiver stalls, the result holds in the output
// register; new beats are still taken, and a following result waits in
// the send stage until it is free.
//------------------------------------------------------------------------------
module window_minmax_confidence_map_core #(
    parameter int unsigned MAX_WIDTH   = wmmc_pkg::MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT  = wmmc_pkg::MAX_HEIGHT,
    parameter int unsigned WINDOW_HALF = wmmc_pkg::WINDOW_HALF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [wmmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wmmc_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // prob_sample[16:0], conf_sample[33:17], zero
    input  logic [1:0]  s_axis_tuser,   // frame_start[0], flush[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // combined_conf[16:0], zero
    output logic        m_axis_tlast    // frame_last
);

    localparam int unsigned WIN_LEN = 2 * WINDOW_HALF - 1;
    localparam int unsigned RING    = (WIN_LEN - 1) * MAX_WIDTH + WIN_LEN + 1;
    localparam int unsigned AW      = $clog2(RING);
    localparam int unsigned XW      = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YW      = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned KW      = ((XW > YW) ? XW : YW) + 1;
    localparam int unsigned PW      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int unsigned TW      = $clog2(WIN_LEN + 1);
    localparam int unsigned SW      = wmmc_pkg::SAMPLE_W;
    localparam int unsigned CW      = wmmc_pkg::SIZE_W;

    // Configuration registers.
    logic [CW-1:0] r_cfg_w, r_cfg_h;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= wmmc_pkg::RESET_WIDTH;
            r_cfg_h <= wmmc_pkg::RESET_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == wmmc_pkg::REG_FRAME_WIDTH) r_cfg_w <= i_cfg_data;
            if (i_cfg_idx == wmmc_pkg::REG_FRAME_HEIGHT) r_cfg_h <= i_cfg_data;
        end
    end

    // Clamped sizes that a new frame would latch.
    logic [XW-1:0] cl_w;
    logic [YW-1:0] cl_h;
    always_comb begin
        if (r_cfg_w == '0) cl_w = XW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH) cl_w = XW'(MAX_WIDTH);
        else cl_w = XW'(r_cfg_w);
        if (r_cfg_h == '0) cl_h = YW'(1);
        else if (32'(r_cfg_h) > MAX_HEIGHT) cl_h = YW'(MAX_HEIGHT);
        else cl_h = YW'(r_cfg_h);
    end

    // Frame state: latched sizes, total, input counter, output position.
    logic [XW-1:0] r_lat_w;
    logic [YW-1:0] r_lat_h;
    logic [PW-1:0] r_total, r_in_cnt, r_out_cnt, r_lag;
    logic [AW-1:0] r_in_addr, r_out_addr;
    logic [XW-1:0] r_oj;
    logic [YW-1:0] r_oi;

    // Memories.
    logic [SW-1:0] prob_mem [RING];
    logic [SW-1:0] conf_mem [RING];
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] r_rd_prob, r_rd_conf;
    logic [SW-1:0] in_p, in_c;

    assign in_p = wmmc_pkg::sat_q16(s_axis_tdata[16:0]);
    assign in_c = wmmc_pkg::sat_q16(s_axis_tdata[33:17]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            prob_mem[wr_addr] <= in_p;
            conf_mem[wr_addr] <= in_c;
        end
        r_rd_prob <= prob_mem[rd_addr];
        r_rd_conf <= conf_mem[rd_addr];
    end

    // Sequencer registers.
    wmmc_pkg::t_state r_state, n_state;
    logic [TW-1:0] r_ta, r_tb;
    logic [AW-1:0] r_row_addr, r_tap_addr;
    logic          r_rd_vld, r_first, r_last_tap, r_frame_last;
    logic [SW-1:0] r_p, r_c, r_wmin, r_wmax;
    logic [SW-1:0] r_t1;
    logic [SW-1:0] r_res;
    logic          r_ovalid;

    // Ring address wrap helpers.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(RING)) s = s - (AW+1)'(RING);
        ring_add = s[AW-1:0];
    endfunction

    // Axis filter test.
    function automatic logic axis_ok(input logic [KW-1:0] k, input logic [KW-1:0] n);
        axis_ok = (k >= KW'(WINDOW_HALF)) &&
                  (k + KW'(WINDOW_HALF + 1) < n) &&
                  (k + KW'(WIN_LEN - 1) < n);
    endfunction

    logic accept, is_flush, start, pix_ok, emit_now, drain_now, send_go;
    logic [PW-1:0] tot_n, lag_n;
    logic [PW-1:0] in_next;
    logic [AW-1:0] step_w;

    assign s_axis_tready = (r_state == wmmc_pkg::ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_flush = s_axis_tuser[1];
    assign start    = !is_flush && (s_axis_tuser[0] || r_in_cnt == '0);
    assign tot_n    = start ? PW'(cl_w) * PW'(cl_h) : r_total;
    assign lag_n    = start ? PW'(WIN_LEN - 1) * PW'(cl_w) + PW'(WIN_LEN - 1) : r_lag;
    assign step_w   = AW'(r_lat_w);
    assign wr_addr  = start ? '0 : r_in_addr;
    // The send stage moves on once the output register is free.
    assign send_go  = (r_state == wmmc_pkg::ST_SEND) && (!r_ovalid || m_axis_tready);

    always_comb begin
        logic [PW-1:0] inc, outc;
        inc  = start ? '0 : r_in_cnt;
        outc = start ? '0 : r_out_cnt;
        pix_ok    = !is_flush && inc < tot_n;
        in_next   = inc + PW'(1);
        emit_now  = pix_ok && outc < tot_n && in_next > outc + lag_n;
        drain_now = !pix_ok && inc >= tot_n && outc < tot_n;
    end

    assign mem_we = accept && pix_ok;

    // Next state and read address.
    always_comb begin
        n_state = r_state;
        rd_addr = r_tap_addr;
        case (r_state)
            wmmc_pkg::ST_IDLE: begin
                if (accept && (emit_now || drain_now)) n_state = wmmc_pkg::ST_SCAN;
            end
            wmmc_pkg::ST_SCAN: begin
                if (r_rd_vld && r_last_tap) n_state = wmmc_pkg::ST_MATH;
            end
            wmmc_pkg::ST_MATH: n_state = wmmc_pkg::ST_SEND;
            wmmc_pkg::ST_SEND: begin
                if (send_go) n_state = wmmc_pkg::ST_IDLE;
            end
            default: n_state = wmmc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wmmc_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    // Frame counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_w <= XW'(MAX_WIDTH < 640 ? MAX_WIDTH : 640);
            r_lat_h <= YW'(MAX_HEIGHT < 480 ? MAX_HEIGHT : 480);
            r_total <= '0;
            r_lag <= '0;
            r_in_cnt <= '0;
            r_in_addr <= '0;
            r_out_cnt <= '0;
            r_out_addr <= '0;
            r_oi <= '0;
            r_oj <= '0;
        end else begin
            // A frame start always stores its pixel, so the input side is
            // restarted through the write below.
            if (accept && start) begin
                r_lat_w <= cl_w;
                r_lat_h <= cl_h;
                r_total <= tot_n;
                r_lag <= lag_n;
                r_out_cnt <= '0;
                r_out_addr <= '0;
                r_oi <= '0;
                r_oj <= '0;
            end
            if (mem_we) begin
                r_in_cnt <= in_next;
                r_in_addr <= ring_add(wr_addr, AW'(1));
            end
            if (send_go) begin
                r_out_cnt <= r_out_cnt + PW'(1);
                r_out_addr <= ring_add(r_out_addr, AW'(1));
                if (r_oj == r_lat_w - XW'(1)) begin
                    r_oj <= '0;
                    r_oi <= r_oi + YW'(1);
                end else begin
                    r_oj <= r_oj + XW'(1);
                end
            end
        end
    end

    // Window scan: one memory read per tap, min/max folded as data returns.
    logic [SW-1:0] fold_min, fold_max;
    always_comb begin
        fold_min = r_wmin;
        fold_max = r_wmax;
        if (r_rd_vld) begin
            if (r_first) begin
                fold_min = r_rd_prob;
                fold_max = r_rd_prob;
            end else begin
                if (r_rd_prob < r_wmin) fold_min = r_rd_prob;
                if (r_rd_prob > r_wmax) fold_max = r_rd_prob;
            end
        end
    end

    logic [SW-1:0] spread, dev;
    logic [2*SW-1:0] prod1, prod2;
    logic [SW:0]     dbl;
    assign spread = wmmc_pkg::ONE_Q16 - (r_wmax - r_wmin);
    assign dev = (r_p >= wmmc_pkg::HALF_Q16) ? r_p - wmmc_pkg::HALF_Q16
                                             : wmmc_pkg::HALF_Q16 - r_p;
    assign prod1 = spread * dev;
    assign prod2 = r_t1 * r_c;
    // The second product is truncated to Q1.16 before it is doubled.
    assign dbl   = {prod2[SW+15:16], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
            r_last_tap <= 1'b0;
        end else begin
            if (send_go) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                wmmc_pkg::ST_IDLE: begin
                    r_rd_vld <= 1'b0;
                    // First tap is the output pixel itself: yields p and c.
                    if (n_state == wmmc_pkg::ST_SCAN) begin
                        r_tap_addr <= start ? '0 : r_out_addr;
                        r_row_addr <= start ? '0 : r_out_addr;
                        r_ta <= '0;
                        r_tb <= '0;
                        r_first <= 1'b1;
                        r_last_tap <= 1'b0;
                    end
                end
                wmmc_pkg::ST_SCAN: begin
                    r_wmin <= fold_min;
                    r_wmax <= fold_max;
                    if (r_rd_vld && r_first) begin
                        r_p <= r_rd_prob;
                        r_c <= r_rd_conf;
                        r_first <= 1'b0;
                    end
                    if (!r_rd_vld) begin
                        // Pixel read issued; decide whether a window follows.
                        r_rd_vld <= 1'b1;
                        r_last_tap <= !(axis_ok(KW'(r_oi), KW'(r_lat_h)) &&
                                       axis_ok(KW'(r_oj), KW'(r_lat_w)));
                    end else if (!r_last_tap) begin
                        // Walk the window taps row by row.
                        if (r_tb == TW'(WIN_LEN - 1)) begin
                            r_tb <= '0;
                            r_ta <= r_ta + TW'(1);
                            r_row_addr <= ring_add(r_row_addr, step_w);
                            r_tap_addr <= ring_add(r_row_addr, step_w);
                        end else begin
                            r_tb <= r_tb + TW'(1);
                            r_tap_addr <= ring_add(r_tap_addr, AW'(1));
                        end
                        if (r_ta == TW'(WIN_LEN - 1) && r_tb == TW'(WIN_LEN - 1))
                            r_last_tap <= 1'b1;
                    end
                end
                wmmc_pkg::ST_MATH: begin
                    r_rd_vld <= 1'b0;
                    r_t1 <= prod1[SW+15:16];
                end
                wmmc_pkg::ST_SEND: begin
                    if (send_go) begin
                        r_res <= (dbl > (SW+1)'(wmmc_pkg::ONE_Q16))
                                 ? wmmc_pkg::ONE_Q16 : dbl[SW-1:0];
                        r_frame_last <= (r_out_cnt + PW'(1) == r_total);
                    end
                end
                default: r_rd_vld <= 1'b0;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_res};
    assign m_axis_tlast  = r_frame_last;

endmodule

// ===== hw/rtl/wmmc_checker.sv =====
//------------------------------------------------------------------------------
// wmmc_checker
// Port-level checks of the confidence map core.
//------------------------------------------------------------------------------
module wmmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A result waiting to be taken holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Combined confidence never exceeds one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 24'd65536)
        else $error("result above one");

    // A result waiting to be taken is not withdrawn.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Reset leaves the output channel empty.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind window_minmax_confidence_map_core wmmc_checker u_wmmc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// ===== sim/window_minmax_confidence_map_core_tb.sv =====
//------------------------------------------------------------------------------
// window_minmax_confidence_map_core_tb
// Self-checking bench for the windowed min/max confidence map core.
//------------------------------------------------------------------------------
// Pixel beats and flush beats go into the core, and a scoreboard class keeps
// its own line store and position counters. From those it predicts every
// combined-confidence result and compares it with what the core sends.
// A short directed part covers single-pixel frames, sample saturation,
// ignored flushes and pixels that arrive past the end of a frame. Random
// frames follow, with clamped and extreme sizes. Sender gaps and receiver
// stalls change from phase to phase.
//------------------------------------------------------------------------------
module window_minmax_confidence_map_core_tb;

    localparam int unsigned WIN_LEN   = 2 * wmmc_pkg::WINDOW_HALF - 1;
    localparam int unsigned RING_LEN  = (WIN_LEN - 1) * wmmc_pkg::MAX_WIDTH + WIN_LEN + 1;
    localparam int          NUM_ITEMS = 1850;
    localparam int          STALL_MAX = 3000;
    localparam int          SETTLE    = 40;

    typedef struct packed {
        logic [wmmc_pkg::SAMPLE_W-1:0] conf;
        logic                          last;
    } t_result;

    // Predicts the core's results and checks them in order.
    class conf_map_scoreboard;
        logic [wmmc_pkg::SIZE_W-1:0]   reg_width;
        logic [wmmc_pkg::SIZE_W-1:0]   reg_height;
        logic [wmmc_pkg::SAMPLE_W-1:0] prob_ring [RING_LEN];
        logic [wmmc_pkg::SAMPLE_W-1:0] conf_ring [RING_LEN];
        int unsigned                   in_pos;
        int unsigned                   out_pos;
        int unsigned                   frame_w;
        int unsigned                   frame_h;
        t_result                       expected_q [$];
        int                            errors;

        function new();
            reg_width  = wmmc_pkg::RESET_WIDTH;
            reg_height = wmmc_pkg::RESET_HEIGHT;
            in_pos     = 0;
            out_pos    = 0;
            errors     = 0;
            frame_w    = clamp_size(reg_width, wmmc_pkg::MAX_WIDTH);
            frame_h    = clamp_size(reg_height, wmmc_pkg::MAX_HEIGHT);
        endfunction

        function int unsigned clamp_size(logic [wmmc_pkg::SIZE_W-1:0] v,
                                         int unsigned maxv);
            if (v == 0) return 1;
            return (v > maxv) ? maxv : v;
        endfunction

        function logic [wmmc_pkg::SAMPLE_W-1:0] sat(logic [wmmc_pkg::SAMPLE_W-1:0] v);
            return (v > wmmc_pkg::ONE_Q16) ? wmmc_pkg::ONE_Q16 : v;
        endfunction

        function void write_reg(logic [wmmc_pkg::CFG_IDX_W-1:0] idx,
                                logic [wmmc_pkg::SIZE_W-1:0] val);
            if (idx == wmmc_pkg::REG_FRAME_WIDTH) reg_width = val;
            else if (idx == wmmc_pkg::REG_FRAME_HEIGHT) reg_height = val;
        endfunction

        function bit axis_filtered(int unsigned k, int unsigned n);
            return k >= wmmc_pkg::WINDOW_HALF && k + wmmc_pkg::WINDOW_HALF + 1 < n &&
                   k + WIN_LEN - 1 < n;
        endfunction

        function int unsigned results_left();
            return frame_w * frame_h - out_pos;
        endfunction

        // Computes the result of the next output pixel.
        function void emit_next();
            int unsigned   row;
            int unsigned   col;
            logic [16:0]   p;
            logic [16:0]   c;
            logic [16:0]   wmin;
            logic [16:0]   wmax;
            logic [16:0]   v;
            logic [63:0]   spread;
            logic [63:0]   dev;
            logic [63:0]   prod;
            t_result       r;
            row  = out_pos / frame_w;
            col  = out_pos % frame_w;
            p    = prob_ring[out_pos % RING_LEN];
            c    = conf_ring[out_pos % RING_LEN];
            wmin = p;
            wmax = p;
            if (axis_filtered(row, frame_h) && axis_filtered(col, frame_w)) begin
                wmin = wmmc_pkg::ONE_Q16;
                wmax = 0;
                for (int a = 0; a < WIN_LEN; a++) begin
                    for (int b = 0; b < WIN_LEN; b++) begin
                        v = prob_ring[((row + a) * frame_w + col + b) % RING_LEN];
                        if (v < wmin) wmin = v;
                        if (v > wmax) wmax = v;
                    end
                end
            end
            spread = 64'(wmmc_pkg::ONE_Q16) - 64'(wmax - wmin);
            dev    = (p >= wmmc_pkg::HALF_Q16) ? 64'(p - wmmc_pkg::HALF_Q16)
                                               : 64'(wmmc_pkg::HALF_Q16 - p);
            prod   = (spread * dev) >> 16;
            prod   = ((prod * 64'(c)) >> 16) * 2;
            r.conf = (prod > 64'(wmmc_pkg::ONE_Q16)) ? wmmc_pkg::ONE_Q16 : prod[16:0];
            r.last = (out_pos + 1 == frame_w * frame_h);
            expected_q.insert(expected_q.size(), r);
            out_pos++;
        endfunction

        function void drain();
            if (in_pos >= frame_w * frame_h && out_pos < frame_w * frame_h) emit_next();
        endfunction

        // Notes one accepted input beat.
        function void note_beat(logic [16:0] p_raw, logic [16:0] c_raw, bit start,
                                bit flush);
            logic [16:0] p;
            logic [16:0] c;
            p = sat(p_raw);
            c = sat(c_raw);
            if (flush) begin
                drain();
                return;
            end
            if (start || in_pos == 0) begin
                frame_w = clamp_size(reg_width, wmmc_pkg::MAX_WIDTH);
                frame_h = clamp_size(reg_height, wmmc_pkg::MAX_HEIGHT);
                in_pos  = 0;
                out_pos = 0;
            end
            if (in_pos >= frame_w * frame_h) begin
                drain();
                return;
            end
            prob_ring[in_pos % RING_LEN] = p;
            conf_ring[in_pos % RING_LEN] = c;
            in_pos++;
            if (out_pos < frame_w * frame_h &&
                in_pos > out_pos + (WIN_LEN - 1) * frame_w + WIN_LEN - 1) emit_next();
        endfunction

        function void check_result(logic [16:0] got_conf, logic got_last);
            t_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result conf=%0d last=%0b", $time,
                         got_conf, got_last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got_conf !== e.conf) begin
                $display("%0t: combined_conf mismatch expected=%0d actual=%0d", $time,
                         e.conf, got_conf);
                errors++;
            end
            if (got_last !== e.last) begin
                $display("%0t: frame_last mismatch expected=%0b actual=%0b", $time,
                         e.last, got_last);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [wmmc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [wmmc_pkg::SIZE_W-1:0]    i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [39:0]                    s_axis_tdata;
    logic [1:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [23:0]                    m_axis_tdata;
    logic                           m_axis_tlast;

    conf_map_scoreboard sb;
    int                 sender_idle_pct;
    int                 receiver_stall_pct;
    int                 items_sent;
    int                 quiet_cycles;

    window_minmax_confidence_map_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: random stalls, result check on every accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[16:0], m_axis_tlast);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends one beat, with random sender gaps before it.
    task automatic send_beat(logic [16:0] p, logic [16:0] c, bit start, bit flush);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, c, p};
        s_axis_tuser  <= {flush, start};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_beat(p, c, start, flush);
        items_sent++;
    endtask

    function automatic logic [16:0] rand_sample();
        if ($urandom_range(9) == 0) return 17'($urandom);
        return 17'($urandom_range(65536));
    endfunction

    // Waits until every expected result has arrived, then lets the core settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(logic [wmmc_pkg::SIZE_W-1:0] w,
                              logic [wmmc_pkg::SIZE_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= wmmc_pkg::REG_FRAME_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        sb.write_reg(wmmc_pkg::REG_FRAME_WIDTH, w);
        i_cfg_idx  <= wmmc_pkg::REG_FRAME_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        sb.write_reg(wmmc_pkg::REG_FRAME_HEIGHT, h);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_idling(int phase);
        case (phase % 5)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
            3: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        endcase
    endtask

    // One frame of random pixels with some noise, then the tail flushes.
    task automatic run_frame(int unsigned max_pixels);
        int unsigned npix;
        int unsigned left;
        npix = sb.clamp_size(sb.reg_width, wmmc_pkg::MAX_WIDTH) *
               sb.clamp_size(sb.reg_height, wmmc_pkg::MAX_HEIGHT);
        if (npix > max_pixels) npix = max_pixels;
        // Now and then a frame is cut short and restarted.
        if ($urandom_range(19) == 0) npix = $urandom_range(npix, 1);
        for (int unsigned k = 0; k < npix; k++) begin
            if ($urandom_range(24) == 0)
                send_beat(rand_sample(), rand_sample(), 1'($urandom_range(1)), 1'b1);
            send_beat(rand_sample(), rand_sample(), k == 0, 1'b0);
        end
        if ($urandom_range(9) == 0) send_beat(rand_sample(), rand_sample(), 1'b0, 1'b0);
        left = sb.results_left();
        if (npix < sb.frame_w * sb.frame_h) left = 0;
        for (int unsigned k = 0; k < left; k++)
            send_beat(rand_sample(), rand_sample(), 1'b0, ($urandom_range(9) != 0));
        if ($urandom_range(4) == 0) send_beat(rand_sample(), rand_sample(), 1'b0, 1'b1);
    endtask

    initial begin
        int phase;
        sb                 = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        items_sent         = 0;
        quiet_cycles       = 0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = wmmc_pkg::REG_FRAME_WIDTH;
        i_cfg_data         = '0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size: a few pixels only, the lag is far longer.
        for (int k = 0; k < 4; k++) send_beat(rand_sample(), rand_sample(), k == 0, 1'b0);
        wait_drained();

        // Directed: single-pixel frames, sample extremes, flush corner cases.
        write_size(11'd0, 11'd0);
        send_beat(17'd0, wmmc_pkg::ONE_Q16, 1'b1, 1'b0);
        send_beat(17'd0, 17'd0, 1'b0, 1'b1);
        send_beat(wmmc_pkg::ONE_Q16, wmmc_pkg::ONE_Q16, 1'b1, 1'b0);
        send_beat(17'd0, 17'd0, 1'b1, 1'b1);
        send_beat(17'h1FFFF, 17'h1FFFF, 1'b1, 1'b0);
        send_beat(17'd5, 17'd5, 1'b0, 1'b0);
        send_beat(17'd0, 17'd0, 1'b0, 1'b1);
        send_beat(wmmc_pkg::HALF_Q16, wmmc_pkg::ONE_Q16, 1'b1, 1'b0);
        send_beat(17'd0, 17'd0, 1'b0, 1'b1);
        send_beat(17'd32767, 17'h10001, 1'b1, 1'b0);
        send_beat(17'h1FFFF, 17'h1FFFF, 1'b0, 1'b1);
        send_beat(17'h0AAAA, 17'h15555, 1'b1, 1'b0);
        send_beat(17'h15555, 17'h0AAAA, 1'b0, 1'b0);
        wait_drained();

        // Random phases: extreme sizes first, then small frames.
        phase = 0;
        while (items_sent < NUM_ITEMS) begin
            set_idling(phase);
            case (phase)
                0: write_size(11'd2047, 11'd1);
                1: write_size(11'd1, 11'd2047);
                2: write_size(11'd8, 11'd8);
                3: write_size(11'd1024, 11'd0);
                default: write_size(11'($urandom_range(16, 1)), 11'($urandom_range(16, 1)));
            endcase
            for (int f = $urandom_range(2, 1); f > 0; f--)
                run_frame((phase == 1) ? 60 : 40 + (phase == 3 ? 0 : 300));
            wait_drained();
            phase++;
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
